>>> rtl/cfl_pkg.sv
// Shared types and constants for the CFL timestep minimum reduction block.
// No dependencies; the other RTL files except cfl_chk refer to this package by scoped names.
`default_nettype none
package cfl_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracW    = 16;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  // Queue depth between front and back; keep it a power of two.
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [DataW-1:0] LimitAllOnes = {DataW{1'b1}};
  localparam logic [DataW-1:0] SpeedFloor   = DataW'(1);

  // One classified cell request on its way from front to back
  typedef struct packed {
    logic [DataW-1:0] width_x;
    logic [DataW-1:0] width_z;
    logic [DataW-1:0] speed_x;
    logic [DataW-1:0] speed_z;
    logic             final_cell;
  } cell_t;

endpackage
`default_nettype wire

>>> rtl/cfl_front.sv
// Front end: accepts cell requests, forms the floored peak speed per axis.
// Depends on cfl_pkg; feeds cfl_fifo.
`default_nettype none
module cfl_front (
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic signed [31:0]          vel_left_i,
  input  wire logic signed [31:0]          vel_right_i,
  input  wire logic signed [31:0]          vel_up_i,
  input  wire logic signed [31:0]          vel_down_i,
  input  wire logic        [31:0]          width_x_i,
  input  wire logic        [31:0]          width_z_i,
  input  wire logic                        final_cell_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output cfl_pkg::cell_t                   q_entry_o
);

  // Magnitude of a signed word; the most negative value maps to 2^31
  function automatic logic [cfl_pkg::DataW-1:0] mag(input logic [cfl_pkg::DataW-1:0] v);
    mag = v[cfl_pkg::DataW-1] ? (~v + cfl_pkg::DataW'(1)) : v;
  endfunction

  // Larger of two magnitudes, floored at one LSB
  function automatic logic [cfl_pkg::DataW-1:0] peak(input logic [cfl_pkg::DataW-1:0] a,
                                                     input logic [cfl_pkg::DataW-1:0] b);
    logic [cfl_pkg::DataW-1:0] ma;
    logic [cfl_pkg::DataW-1:0] mb;
    logic [cfl_pkg::DataW-1:0] m;
    ma = mag(a);
    mb = mag(b);
    m  = (ma > mb) ? ma : mb;
    peak = (m < cfl_pkg::SpeedFloor) ? cfl_pkg::SpeedFloor : m;
  endfunction

  // Hold the request while the queue is full
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the cell
  always_comb begin
    q_entry_o.width_x    = width_x_i;
    q_entry_o.width_z    = width_z_i;
    q_entry_o.speed_x    = peak($unsigned(vel_left_i), $unsigned(vel_right_i));
    q_entry_o.speed_z    = peak($unsigned(vel_up_i), $unsigned(vel_down_i));
    q_entry_o.final_cell = final_cell_i;
  end

endmodule
`default_nettype wire

>>> rtl/cfl_fifo.sv
// Short request queue between the front end and the divider back end.
// Depends on cfl_pkg for the entry type and depth.
`default_nettype none
module cfl_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cfl_pkg::cell_t  entry_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output cfl_pkg::cell_t       entry_o,
  output logic                 empty_o
);

  cfl_pkg::cell_t                  mem_q [cfl_pkg::QDepth];
  logic [cfl_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cfl_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cfl_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == cfl_pkg::QCntW'(cfl_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Advance pointers; they wrap naturally at a power-of-two depth
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + cfl_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + cfl_pkg::QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + cfl_pkg::QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - cfl_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store payload; no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfl_div.sv
// Radix-2 restoring divider: (width << 16) / speed, saturated to 32 bits.
// Depends on cfl_pkg; shared by both axes in cfl_back.
`default_nettype none
module cfl_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [cfl_pkg::DataW-1:0] width_i,
  input  wire logic [cfl_pkg::DataW-1:0] speed_i,
  output logic                           done_o,
  output logic [cfl_pkg::DataW-1:0]      quot_o
);

  localparam int unsigned W  = cfl_pkg::DataW;
  localparam int unsigned FW = cfl_pkg::FracW;

  logic                        busy_q;
  logic                        done_q;
  logic [cfl_pkg::DivCntW-1:0] cnt_q;
  logic [W-1:0]                rem_q, rem_d;
  logic [W-1:0]                quo_q, quo_d;
  logic [W-1:0]                div_q;
  logic [W:0]                  trial;
  logic [W:0]                  diff;
  logic                        ge;
  logic                        sat;

  // Quotient overflows 32 bits exactly when the integer part reaches the speed
  assign sat = ({{FW{1'b0}}, width_i[W-1:FW]} >= speed_i);

  // One quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= !sat;
        done_q <= sat;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q  <= cnt_q + cfl_pkg::DivCntW'(1);
        done_q <= (cnt_q == cfl_pkg::DivCntW'(cfl_pkg::DivSteps - 1));
        if (cnt_q == cfl_pkg::DivCntW'(cfl_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // Load operands or iterate; saturation lands directly in the quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= speed_i;
      rem_q <= {{FW{1'b0}}, width_i[W-1:FW]};
      quo_q <= sat ? cfl_pkg::LimitAllOnes : {width_i[FW-1:0], {FW{1'b0}}};
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfl_back.sv
// Back end: runs both quotients of a cell through one divider, keeps the
// running minimum and holds the result register. Depends on cfl_pkg, cfl_div.
`default_nettype none
module cfl_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      q_empty_i,
  input  wire cfl_pkg::cell_t            q_entry_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [cfl_pkg::DataW-1:0]      step_limit_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Z,
    S_DONE
  } state_e;

  state_e                        state_q;
  cfl_pkg::cell_t                cur_q;
  logic [cfl_pkg::DataW-1:0]     tx_q;
  logic [cfl_pkg::DataW-1:0]     tz_q;
  logic [cfl_pkg::DataW-1:0]     min_q;
  logic [cfl_pkg::DataW-1:0]     min_next;
  logic [cfl_pkg::DataW-1:0]     cell_min;
  logic                          out_valid_q;
  logic [cfl_pkg::DataW-1:0]     step_q;
  logic                          div_start;
  logic [cfl_pkg::DataW-1:0]     div_width;
  logic [cfl_pkg::DataW-1:0]     div_speed;
  logic                          div_done;
  logic [cfl_pkg::DataW-1:0]     div_quot;
  logic                          out_free;
  logic                          out_load;

  assign q_pop_o      = (state_q == S_IDLE) && !q_empty_i;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_load     = (state_q == S_DONE) && cur_q.final_cell && out_free;
  assign out_valid_o  = out_valid_q;
  assign step_limit_o = step_q;

  // Pick divider operands: x from the queue head, z from the held cell
  always_comb begin
    div_start = 1'b0;
    div_width = q_entry_i.width_x;
    div_speed = q_entry_i.speed_x;
    unique case (state_q)
      S_IDLE: begin
        div_start = !q_empty_i;
      end
      S_DIV_X: begin
        div_start = div_done;
        div_width = cur_q.width_z;
        div_speed = cur_q.speed_z;
      end
      S_DIV_Z, S_DONE: begin
        div_start = 1'b0;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Fold this cell into the running minimum
  always_comb begin
    cell_min = (tx_q < tz_q) ? tx_q : tz_q;
    min_next = (cell_min < min_q) ? cell_min : min_q;
  end

  cfl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .width_i (div_width),
    .speed_i (div_speed),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= cfl_pkg::LimitAllOnes;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new result, or drop the old one once it is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            state_q <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            state_q <= S_DIV_Z;
          end
        end
        S_DIV_Z: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!cur_q.final_cell) begin
            min_q   <= min_next;
            state_q <= S_IDLE;
          end else if (out_free) begin
            min_q       <= cfl_pkg::LimitAllOnes;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Capture payload: held cell, both quotients, emitted limit
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
    if (div_done && (state_q == S_DIV_X)) begin
      tx_q <= div_quot;
    end
    if (div_done && (state_q == S_DIV_Z)) begin
      tz_q <= div_quot;
    end
    if (out_load) begin
      step_q <= min_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/cfl_timestep_min_reduction.sv
// CFL advective timestep limit: streaming minimum of per-cell quotients.
// Top level; depends on cfl_pkg, cfl_front, cfl_fifo, cfl_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one grid cell per request:
//   four signed Q16.16 edge velocities, the two unsigned Q16.16 widths and
//   final_cell. The output channel (out_valid_o / out_stall_i) carries one
//   step_limit_o per domain, issued on the request marked final_cell.
//   A request is taken on a rising edge with valid high and stall low.
// The back end takes one cell at a time, dequeuing another only after it has
//   folded the current one. It owns a single radix-2 divider that resolves one
//   quotient bit per cycle; each cell needs two quotients of 32 steps and one
//   fold into the running minimum. A saturating quotient skips the steps.
// The front end and a two-entry queue keep accepting requests while the
//   divider works and while a result waits in the output register.
// Receiver stall: the result holds in its register; a later final cell waits
//   in the back end until that register is free, and the queue then fills.
// Reset: rst_ni clears the queue, the sequencer and the output valid, and
//   returns the running minimum to all ones.
`default_nettype none
module cfl_timestep_min_reduction (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] vel_left_i,
  input  wire logic signed [31:0] vel_right_i,
  input  wire logic signed [31:0] vel_up_i,
  input  wire logic signed [31:0] vel_down_i,
  input  wire logic        [31:0] width_x_i,
  input  wire logic        [31:0] width_z_i,
  input  wire logic               final_cell_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [31:0] step_limit_o
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  cfl_pkg::cell_t q_wr_entry;
  cfl_pkg::cell_t q_rd_entry;

  cfl_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .vel_left_i   (vel_left_i),
    .vel_right_i  (vel_right_i),
    .vel_up_i     (vel_up_i),
    .vel_down_i   (vel_down_i),
    .width_x_i    (width_x_i),
    .width_z_i    (width_z_i),
    .final_cell_i (final_cell_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_wr_entry)
  );

  cfl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_rd_entry),
    .empty_o (q_empty)
  );

  cfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .step_limit_o (step_limit_o)
  );

endmodule
`default_nettype wire

>>> rtl/cfl_chk.sv
// Port-level checks for cfl_timestep_min_reduction, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module cfl_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] step_limit_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(step_limit_o))
    else $error("stalled result changed or dropped");

  // Drop valid only after the result is taken
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result withdrawn without being taken");

  // Keep the handshake outputs known out of reset
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(out_valid_o) && !$isunknown(in_stall_o))
    else $error("handshake output unknown");

  // Stall only once requests have been accepted since reset
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a preceding request");

endmodule

bind cfl_timestep_min_reduction cfl_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .step_limit_o (step_limit_o)
);
`default_nettype wire
